// File: rtl/rsi_window_indicator_top_assert.svh
// Assertion macros for the RSI window indicator top level.
`ifndef RSI_WINDOW_INDICATOR_TOP_ASSERT_SVH
`define RSI_WINDOW_INDICATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RSI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsi_window_indicator: implication check failed");
// Next-cycle implication, disabled during reset.
`define RSI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsi_window_indicator: next-cycle check failed");
`else
`define RSI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RSI_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/rsi_pkg.sv
// Shared constants and controller/datapath types for the RSI window indicator.
`default_nettype none
package rsi_pkg;

  // Default sizes handed down from the top level.
  localparam int DEF_MAX_WINDOW = 64;
  localparam int DEF_PRICE_BITS = 32;

  // Window length register.
  localparam int WINDOW_REG_BITS = 7;
  localparam logic [WINDOW_REG_BITS-1:0] WINDOW_RESET = 7'd14;

  // Result format: hundredths of a percent, 0 to 10000.
  localparam int QUOT_BITS    = 14;
  localparam int DIV_IDX_BITS = 4;
  localparam logic [QUOT_BITS-1:0] RSI_SCALE = 14'd10000;
  localparam logic [QUOT_BITS-1:0] RSI_FLAT  = 14'd5000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                    capture;
    logic                    update;
    logic                    mul;
    logic                    div_step;
    logic [DIV_IDX_BITS-1:0] div_bit;
    logic                    load_out;
  } rsi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic result_due;
    logic out_free;
  } rsi_status_t;

endpackage
`default_nettype wire

// File: rtl/rsi_stream_if.sv
// Handshake channels for candle words in and RSI words out.
`default_nettype none
interface rsi_candle_if import rsi_pkg::*; #(
  parameter int PRICE_BITS = DEF_PRICE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] open_price;
  logic [PRICE_BITS-1:0] close_price;

  modport source (output valid, output open_price, output close_price, input ready);
  modport sink   (input valid, input open_price, input close_price, output ready);
endinterface

interface rsi_result_if import rsi_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [QUOT_BITS-1:0] rsi_hundredths;

  modport source (output valid, output rsi_hundredths, input ready);
  modport sink   (input valid, input rsi_hundredths, output ready);
endinterface
`default_nettype wire

// File: rtl/rsi_ctrl.sv
// Controller state machine that sequences update, scaling and division.
`default_nettype none
module rsi_ctrl import rsi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire rsi_status_t status,
  output rsi_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0]              state;
  logic [2:0]              state_next;
  logic [DIV_IDX_BITS-1:0] div_bit;
  logic [DIV_IDX_BITS-1:0] div_bit_next;

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    div_bit_next = div_bit;
    cmd          = '0;
    cmd.div_bit  = div_bit;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = status.result_due ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul      = 1'b1;
        div_bit_next = DIV_IDX_BITS'(QUOT_BITS - 1);
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_bit == '0) begin
          state_next = S_LOAD;
        end else begin
          div_bit_next = div_bit - 1'b1;
        end
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_bit <= '0;
    end else begin
      state   <= state_next;
      div_bit <= div_bit_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rsi_datapath.sv
// Move ring, running sums, restoring divider and output register.
`default_nettype none
module rsi_datapath import rsi_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int PRICE_BITS = DEF_PRICE_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [WINDOW_REG_BITS-1:0] cfg_data,
  input  wire logic [PRICE_BITS-1:0]      open_price,
  input  wire logic [PRICE_BITS-1:0]      close_price,
  input  wire rsi_cmd_t                   cmd,
  output rsi_status_t                     status,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [QUOT_BITS-1:0]            out_data
);

  localparam int SLOT_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS  = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int PROD_BITS = SUM_BITS + QUOT_BITS;

  // Effective window is the register value clamped to 1..MAX_WINDOW.
  function automatic logic [WIN_BITS-1:0] clamp_window(input logic [WINDOW_REG_BITS-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      return WIN_BITS'(1);
    end else if (v32 > 32'(MAX_WINDOW)) begin
      return WIN_BITS'(MAX_WINDOW);
    end else begin
      return WIN_BITS'(v32);
    end
  endfunction

  logic [PRICE_BITS:0]   ring [MAX_WINDOW];
  logic [PRICE_BITS:0]   rd_data;
  logic [PRICE_BITS:0]   mv;
  logic [WIN_BITS-1:0]   win;
  logic [WIN_BITS-1:0]   fill;
  logic [SLOT_BITS-1:0]  slot;
  logic [SUM_BITS-1:0]   gain;
  logic [SUM_BITS-1:0]   loss;
  logic [SUM_BITS-1:0]   gain_next;
  logic [SUM_BITS-1:0]   loss_next;
  logic [SUM_BITS-1:0]   total;
  logic [PROD_BITS-1:0]  rem;
  logic [PROD_BITS-1:0]  trial;
  logic [QUOT_BITS-1:0]  quot;
  logic                  flat;
  logic                  full;
  logic                  fill_reaches;
  logic                  slot_wraps;
  logic                  old_pos;
  logic                  mv_pos;
  logic [PRICE_BITS:0]   old_neg;
  logic [PRICE_BITS:0]   mv_neg;
  logic [SUM_BITS-1:0]   gain_sub;
  logic [SUM_BITS-1:0]   loss_sub;
  logic [SUM_BITS-1:0]   gain_add;
  logic [SUM_BITS-1:0]   loss_add;

  // Window status before this candle is counted.
  assign full         = (fill >= win);
  assign fill_reaches = ((WIN_BITS + 1)'(fill) + 1'b1) >= (WIN_BITS + 1)'(win);
  assign slot_wraps   = ((WIN_BITS'(slot) + 1'b1) == win);

  // Sign split of the retiring move and the new move.
  assign old_neg  = -rd_data;
  assign mv_neg   = -mv;
  assign old_pos  = !rd_data[PRICE_BITS] && (rd_data != '0);
  assign mv_pos   = !mv[PRICE_BITS] && (mv != '0);
  assign gain_sub = (full && old_pos) ? SUM_BITS'(rd_data[PRICE_BITS-1:0]) : '0;
  assign loss_sub = (full && !old_pos) ? SUM_BITS'(old_neg[PRICE_BITS-1:0]) : '0;
  assign gain_add = mv_pos ? SUM_BITS'(mv[PRICE_BITS-1:0]) : '0;
  assign loss_add = mv_pos ? '0 : SUM_BITS'(mv_neg[PRICE_BITS-1:0]);
  assign gain_next = gain - gain_sub + gain_add;
  assign loss_next = loss - loss_sub + loss_add;

  // Divisor aligned to the quotient bit under trial.
  assign trial = PROD_BITS'(total) << cmd.div_bit;

  assign status.result_due = fill_reaches;
  assign status.out_free   = !out_valid || out_ready;

  // Ring memory: one read port and one write port, read data registered.
  always_ff @(posedge clk) begin
    rd_data <= ring[slot];
    if (cmd.update) begin
      ring[slot] <= mv;
    end
  end

  // Window register and running window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      win  <= clamp_window(WINDOW_RESET);
      fill <= '0;
      slot <= '0;
      gain <= '0;
      loss <= '0;
    end else if (cfg_write) begin
      win  <= clamp_window(cfg_data);
      fill <= '0;
      slot <= '0;
      gain <= '0;
      loss <= '0;
    end else if (cmd.update) begin
      gain <= gain_next;
      loss <= loss_next;
      slot <= slot_wraps ? '0 : SLOT_BITS'(WIN_BITS'(slot) + 1'b1);
      if (!full) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Candle capture, scaling and restoring division of 10000*gain by the total.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mv <= {1'b0, close_price} - {1'b0, open_price};
    end
    if (cmd.mul) begin
      rem   <= PROD_BITS'(gain) * PROD_BITS'(RSI_SCALE);
      total <= gain + loss;
      flat  <= (gain == '0) && (loss == '0);
      quot  <= '0;
    end else if (cmd.div_step) begin
      if (rem >= trial) begin
        rem                <= rem - trial;
        quot[cmd.div_bit]  <= 1'b1;
      end
    end
  end

  // Output register; a held word waits here while the next candle is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= flat ? RSI_FLAT : quot;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rsi_window_indicator_top.sv
// Top level of the RSI window indicator: controller, datapath and checks.
`default_nettype none
`include "rsi_window_indicator_top_assert.svh"
// Each candle word carries an open and a close price; the block keeps the last
// window_length close-minus-open moves in an on-chip ring together with running
// sums of gains and losses, and once the window is full every candle returns one
// word, floor(10000 * gains / (gains + losses)), the RSI in hundredths of a
// percent (10000 with no losses, 5000 for a flat window). A candle that fills no
// result passes through accept and sum update only; one that yields a result goes
// from acceptance to the output register through accept, ring read and sum update,
// scaling multiply, fourteen restoring-division steps and load; the divider gives
// one quotient bit per cycle. Candles are taken one at a time, and the next candle
// may be accepted while the previous result still waits in the output register.
// Writing the window register empties the window; it must only be written while
// the block is idle. No clearing pass runs after reset.
module rsi_window_indicator_top import rsi_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int PRICE_BITS = DEF_PRICE_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [WINDOW_REG_BITS-1:0] cfg_data,
  rsi_candle_if.sink                      candle,
  rsi_result_if.source                    result
);

  rsi_cmd_t    cmd;
  rsi_status_t status;
  logic        in_ready;

  assign candle.ready = in_ready;

  // Sequencer.
  rsi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (candle.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Window state, divider and output register.
  rsi_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .open_price  (candle.open_price),
    .close_price (candle.close_price),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_data    (result.rsi_hundredths)
  );

  // An accepted candle keeps the block busy for the following cycle.
  `RSI_ASSERT_NXT(a_busy_after_accept, clk, rst, candle.valid && candle.ready, !candle.ready)
  // A result is only loaded when the output register can take it.
  `RSI_ASSERT_IMP(a_load_when_free, clk, rst, cmd.load_out, status.out_free)
  // A loaded result is offered on the output channel in the next cycle.
  `RSI_ASSERT_NXT(a_load_shows_word, clk, rst, cmd.load_out, result.valid)
  // Only an idle controller captures a candle.
  `RSI_ASSERT_IMP(a_capture_idle, clk, rst, cmd.capture, candle.ready && !cmd.div_step)

endmodule
`default_nettype wire
